@@ rtl/mmep_pkg.sv @@
// Types, type codes and helper functions for the MIDI meta event parser.
package mmep_pkg;

	localparam logic [7:0] TYPE_SEQ_NUM   = 8'h00;
	localparam logic [7:0] TYPE_TEXT      = 8'h01;
	localparam logic [7:0] TYPE_COPYRIGHT = 8'h02;
	localparam logic [7:0] TYPE_NAME      = 8'h03;
	localparam logic [7:0] TYPE_CUE       = 8'h07;
	localparam logic [7:0] TYPE_EOT       = 8'h2F;
	localparam logic [7:0] TYPE_TEMPO     = 8'h51;
	localparam logic [7:0] TYPE_SMPTE     = 8'h54;
	localparam logic [7:0] TYPE_TIME_SIG  = 8'h58;
	localparam logic [7:0] TYPE_KEY_SIG   = 8'h59;
	localparam logic [7:0] TYPE_SEQ_SPEC  = 8'h7F;

	localparam logic [2:0] LEN_SEQ_NUM  = 3'd2;
	localparam logic [2:0] LEN_TEMPO    = 3'd3;
	localparam logic [2:0] LEN_SMPTE    = 3'd5;
	localparam logic [2:0] LEN_TIME_SIG = 3'd4;
	localparam logic [2:0] LEN_KEY_SIG  = 3'd2;
	localparam logic [2:0] VLQ_MAX_BYTES = 3'd4;

	typedef struct packed {
		logic       event_start;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic        text_valid;
		logic [7:0]  text_byte;
		logic        event_done;
		logic        length_error;
		logic [7:0]  event_type;
		logic [27:0] event_value;
		logic [28:0] consumed_count;
	} out_item_t;

	function automatic logic [2:0] fixed_length(input logic [7:0] t);
		logic [2:0] len;
		unique case (t)
			TYPE_SEQ_NUM:  len = LEN_SEQ_NUM;
			TYPE_TEMPO:    len = LEN_TEMPO;
			TYPE_SMPTE:    len = LEN_SMPTE;
			TYPE_TIME_SIG: len = LEN_TIME_SIG;
			TYPE_KEY_SIG:  len = LEN_KEY_SIG;
			default:       len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic is_text(input logic [7:0] t);
		return (t == TYPE_TEXT) || (t == TYPE_COPYRIGHT) || (t == TYPE_NAME) || (t == TYPE_CUE);
	endfunction

endpackage

@@ rtl/mmep_if.sv @@
// Valid/ready channel interfaces for the meta event parser input and result.
interface mmep_in_if;
	logic               valid;
	logic               ready;
	mmep_pkg::in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mmep_out_if;
	logic                valid;
	logic                ready;
	mmep_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/midi_meta_event_parser.sv @@
// MIDI file meta event parser: one body byte in, one result out per transfer.
// The result of a byte is registered and valid in the cycle after its transfer.
// Throughput: one byte per cycle; the parser state and the result register
// update in the same cycle, and input stalls only while an untaken result waits.
// Reset (arst_n low, asynchronous): parser idle, all parser state zero, no result pending (result data not reset).
module midi_meta_event_parser (
	input  logic          clk,
	input  logic          arst_n,
	mmep_in_if.sink       body,
	mmep_out_if.source    result
);
	import mmep_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_FIXLEN  = 4'd1,
		PH_FIXDATA = 4'd2,
		PH_VARLEN  = 4'd3,
		PH_PAYLOAD = 4'd4
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  kind_q, kind_d;
	logic [27:0] len_acc_q, len_acc_d;
	logic [2:0]  len_cnt_q, len_cnt_d;
	logic [27:0] remain_q, remain_d;
	logic [23:0] val_acc_q, val_acc_d;
	logic [28:0] byte_cnt_q, byte_cnt_d;

	logic        out_valid_q;
	out_item_t   res_q, res_d;
	logic        accept;
	logic [7:0]  b;
	logic [27:0] remain_dec;
	logic [2:0]  len_cnt_inc;

	assign body.ready   = !out_valid_q || result.ready;
	assign accept       = body.valid && body.ready;
	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	assign b           = body.data.in_byte;
	assign remain_dec  = remain_q - 28'd1;
	assign len_cnt_inc = len_cnt_q + 3'd1;

	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		len_acc_d  = len_acc_q;
		len_cnt_d  = len_cnt_q;
		remain_d   = remain_q;
		val_acc_d  = val_acc_q;
		byte_cnt_d = byte_cnt_q;
		res_d      = '0;

		if (body.data.event_start) begin
			kind_d     = b;
			byte_cnt_d = 29'd1;
			val_acc_d  = '0;
			len_acc_d  = '0;
			len_cnt_d  = '0;
			remain_d   = '0;
			if (b == TYPE_EOT) begin
				res_d.event_done     = 1'b1;
				res_d.consumed_count = 29'd1;
				phase_d              = PH_IDLE;
			end else if (fixed_length(b) != 3'd0) begin
				phase_d = PH_FIXLEN;
			end else begin
				phase_d = PH_VARLEN;
			end
		end else begin
			unique case (phase_q)
				PH_FIXLEN: begin
					byte_cnt_d = byte_cnt_q + 29'd1;
					if (b != {5'd0, fixed_length(kind_q)}) begin
						res_d.event_done   = 1'b1;
						res_d.length_error = 1'b1;
						phase_d            = PH_IDLE;
					end else begin
						remain_d  = {20'd0, b};
						val_acc_d = '0;
						phase_d   = PH_FIXDATA;
					end
				end
				PH_FIXDATA: begin
					byte_cnt_d = byte_cnt_q + 29'd1;
					val_acc_d  = {val_acc_q[15:0], b};
					remain_d   = remain_dec;
					if (remain_dec == 28'd0) begin
						res_d.event_done     = 1'b1;
						res_d.consumed_count = byte_cnt_d;
						if (kind_q == TYPE_SEQ_NUM || kind_q == TYPE_TEMPO)
							res_d.event_value = {4'd0, val_acc_d};
						phase_d = PH_IDLE;
					end
				end
				PH_VARLEN: begin
					byte_cnt_d = byte_cnt_q + 29'd1;
					len_cnt_d  = len_cnt_inc;
					len_acc_d  = {len_acc_q[20:0], b[6:0]};
					if (b[7]) begin
						if (len_cnt_inc >= VLQ_MAX_BYTES) begin
							res_d.event_done   = 1'b1;
							res_d.length_error = 1'b1;
							phase_d            = PH_IDLE;
						end
					end else if (len_acc_d == 28'd0) begin
						res_d.event_done     = 1'b1;
						res_d.consumed_count = byte_cnt_d;
						phase_d              = PH_IDLE;
					end else begin
						remain_d = len_acc_d;
						phase_d  = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					byte_cnt_d = byte_cnt_q + 29'd1;
					if (is_text(kind_q)) begin
						res_d.text_valid = 1'b1;
						res_d.text_byte  = b;
					end
					remain_d = remain_dec;
					if (remain_dec == 28'd0) begin
						res_d.event_done     = 1'b1;
						res_d.consumed_count = byte_cnt_d;
						if (is_text(kind_q) || kind_q == TYPE_SEQ_SPEC)
							res_d.event_value = len_acc_q;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		res_d.event_type = kind_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			kind_q      <= '0;
			len_acc_q   <= '0;
			len_cnt_q   <= '0;
			remain_q    <= '0;
			val_acc_q   <= '0;
			byte_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q    <= phase_d;
				kind_q     <= kind_d;
				len_acc_q  <= len_acc_d;
				len_cnt_q  <= len_cnt_d;
				remain_q   <= remain_d;
				val_acc_q  <= val_acc_d;
				byte_cnt_q <= byte_cnt_d;
			end
			if (accept)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_d;
	end

	// a pending result is never overwritten before it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> $stable(res_q) && out_valid_q)
		else $error("pending result overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.length_error |-> res_q.event_done && res_q.consumed_count == 29'd0)
		else $error("length error without done or with a count");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.event_done |-> res_q.consumed_count == 29'd0
			&& res_q.event_value == 28'd0)
		else $error("count or value outside a finished event");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !body.data.event_start && phase_q == PH_IDLE |=> phase_q == PH_IDLE)
		else $error("idle parser left idle without a type byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.text_valid |-> is_text(res_q.event_type) && !res_q.length_error)
		else $error("text byte from a non-text event");

endmodule
